// ----- sv/four_level_page_table_engine_assert.svh -----
// Assertion macros for the page table engine.
`ifndef FOUR_LEVEL_PAGE_TABLE_ENGINE_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
`define FPTE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fpte assertion failed");
`define FPTE_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("fpte assertion failed");
`else
`define FPTE_ASSERT(lbl, clk, rst_n, prop)
`define FPTE_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ----- sv/fpte_pkg.sv -----
package fpte_pkg;

  localparam int unsigned IDX_W   = 9;
  localparam int unsigned ENTRIES = 512;

  localparam logic [1:0] OP_RESOLVE = 2'd0;
  localparam logic [1:0] OP_MAP     = 2'd1;
  localparam logic [1:0] OP_UNMAP   = 2'd2;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_NOMAP     = 3'd1;
  localparam logic [2:0] STS_NONCANON  = 3'd2;
  localparam logic [2:0] STS_LARGE     = 3'd3;
  localparam logic [2:0] STS_NOMEM     = 3'd4;
  localparam logic [2:0] STS_UNMAPPED  = 3'd5;
  localparam logic [2:0] STS_NOTHING   = 3'd6;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_KBND  = 2'd1;
  localparam logic [1:0] REG_NXEN  = 2'd2;

  localparam logic [1:0] LVL_ROOT = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  localparam logic [39:0] BASE_RST = 40'd256;
  localparam logic [63:0] KBND_RST = 64'hFFFF_8000_0000_0000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] virt_addr;
    logic [51:0] phys_addr;
    logic        want_write;
    logic        want_exec;
    logic        want_global;
    logic        want_user;
  } fpte_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [51:0] out_phys;
    logic        is_writable;
    logic        is_executable;
    logic        is_global;
    logic        is_user;
    logic        was_accessed;
    logic        was_dirty;
  } fpte_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL, ST_ZERO, ST_LINK, ST_LEAF, ST_DONE
  } fpte_state_e;

  typedef enum logic [1:0] {
    ACT_NEXT, ACT_FIN, ACT_ALLOC, ACT_LEAF
  } fpte_act_e;

  function automatic logic [IDX_W-1:0] fpte_idx(input logic [63:0] va,
                                                input logic [1:0] lvl);
    logic [IDX_W-1:0] r;
    unique case (lvl)
      LVL_ROOT: r = va[47:39];
      LVL_PDPT: r = va[38:30];
      LVL_PD:   r = va[29:21];
      default:  r = va[20:12];
    endcase
    return r;
  endfunction

endpackage

// ----- sv/fpte_chan_if.sv -----
interface fpte_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/four_level_page_table_engine.sv -----
// Flow: a request reads and evaluates one table entry per level; map and unmap descend
// to the PD entry and write the leaf entry, map first zeroing and linking a new table
// for each empty entry. The engine takes one word at a time: a request is accepted
// only in the idle state, after the previous result has moved to the response register.
// Reset: control and registers reset at once, then a clearing pass zeroes the table
// memory; no word is taken until it ends, config writes always are.
`include "four_level_page_table_engine_assert.svh"

module four_level_page_table_engine
  import fpte_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fpte_chan_if.sink    req_i,
  fpte_chan_if.source  rsp_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int unsigned PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned AW    = PW + IDX_W;
  localparam int unsigned NW    = PW + 1;
  localparam int unsigned DEPTH = TABLE_PAGES * ENTRIES;

  fpte_state_e state_q, state_d;
  fpte_act_e   act;

  logic [39:0] base_q;
  logic [63:0] kbnd_q;
  logic        nxen_q;

  logic [AW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] nfree_q, nfree_d;
  logic [PW-1:0] page_q, page_d, alloc_q, alloc_d;
  logic [1:0]    lvl_q, lvl_d;
  logic          rsp_valid_q, rsp_valid_d;
  fpte_req_t     req_q, req_d;
  fpte_rsp_t     res_q, res_d, rsp_q, rsp_d;
  logic          nx_q, nx_d, w_q, w_d, u_q, u_d;

  logic [63:0]   tbl_mem_q [DEPTH];
  logic [63:0]   mem_rd_q;
  logic          tbl_we;
  logic [AW-1:0] tbl_wa, tbl_ra;
  logic [63:0]   tbl_wd;

  // ---- config port ----
  logic cfg_we;
  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RST;
      kbnd_q <= KBND_RST;
      nxen_q <= 1'b1;
    end else if (cfg_we) begin
      unique case (paddr[4:3])
        REG_BASE: base_q <= pwdata[39:0];
        REG_KBND: kbnd_q <= pwdata;
        REG_NXEN: nxen_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_BASE: prdata = {24'h0, base_q};
      REG_KBND: prdata = kbnd_q;
      REG_NXEN: prdata = {63'h0, nxen_q};
      default:  prdata = '0;
    endcase
  end

  // ---- table memory ----
  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem_q[tbl_wa] <= tbl_wd;
    mem_rd_q <= tbl_mem_q[tbl_ra];
  end

  // ---- entry decode ----
  logic        is_map, is_unmap, noncanon, req_fire, rsp_free;
  logic [39:0] e_off;
  logic        e_inwin, e_ps, nx_acc, w_acc, u_acc;
  logic [2:0]  fin_sts;
  logic [39:0] alloc_frame;
  logic [63:0] alloc_ent, leaf_ent;
  logic [51:0] res_phys;
  logic [IDX_W-1:0] cur_idx;

  assign is_map   = req_q.opcode == OP_MAP;
  assign is_unmap = req_q.opcode == OP_UNMAP;
  assign noncanon = !((&req_i.data.virt_addr[63:47]) || !(|req_i.data.virt_addr[63:47]));
  assign req_i.ready = state_q == ST_IDLE;
  assign req_fire = req_i.valid & req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  assign cur_idx = fpte_idx(req_q.virt_addr, lvl_q);
  assign e_off   = mem_rd_q[51:12] - base_q;
  assign e_inwin = e_off < 40'(TABLE_PAGES);
  assign e_ps    = mem_rd_q[7] && (lvl_q != LVL_ROOT);
  assign nx_acc  = ((lvl_q == LVL_ROOT) ? 1'b0 : nx_q) | mem_rd_q[63];
  assign w_acc   = ((lvl_q == LVL_ROOT) ? 1'b1 : w_q) & mem_rd_q[1];
  assign u_acc   = ((lvl_q == LVL_ROOT) ? 1'b1 : u_q) & mem_rd_q[2];

  assign alloc_frame = base_q + 40'(alloc_q);
  assign alloc_ent   = {12'h0, alloc_frame, 9'h0,
                        (req_q.virt_addr < kbnd_q), 1'b1, 1'b1};
  assign leaf_ent    = {(!req_q.want_exec && nxen_q), 11'h0, req_q.phys_addr[51:12],
                        3'h0, req_q.want_global, 5'h0, req_q.want_user,
                        req_q.want_write, 1'b1};

  always_comb begin
    unique case (lvl_q)
      LVL_PDPT: res_phys = {mem_rd_q[51:30], req_q.virt_addr[29:0]};
      LVL_PD:   res_phys = {mem_rd_q[51:21], req_q.virt_addr[20:0]};
      default:  res_phys = {mem_rd_q[51:12], req_q.virt_addr[11:0]};
    endcase
  end

  // walk decision on the entry just read
  always_comb begin
    act     = ACT_NEXT;
    fin_sts = STS_OK;
    if (!mem_rd_q[0]) begin
      if (is_map) begin
        if (nfree_q >= NW'(TABLE_PAGES)) begin
          act     = ACT_FIN;
          fin_sts = STS_NOMEM;
        end else begin
          act = ACT_ALLOC;
        end
      end else begin
        act     = ACT_FIN;
        fin_sts = is_unmap ? STS_NOTHING : STS_NOMAP;
      end
    end else if (!is_map && !is_unmap) begin
      if (lvl_q == LVL_PT || e_ps) begin
        act = ACT_FIN;
      end else if (!e_inwin) begin
        act     = ACT_FIN;
        fin_sts = STS_NOMAP;
      end
    end else begin
      if (e_ps) begin
        act     = ACT_FIN;
        fin_sts = STS_LARGE;
      end else if (!e_inwin) begin
        act     = ACT_FIN;
        fin_sts = is_map ? STS_NOMEM : STS_NOTHING;
      end else if (lvl_q == LVL_PD) begin
        act = ACT_LEAF;
      end
    end
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (cnt_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (req_fire) begin
          state_d = (noncanon && req_i.data.opcode != OP_UNMAP) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        unique case (act)
          ACT_FIN:   state_d = ST_DONE;
          ACT_ALLOC: state_d = ST_ZERO;
          ACT_LEAF:  state_d = ST_LEAF;
          default:   state_d = ST_READ;
        endcase
      end
      ST_ZERO: if (&cnt_q[IDX_W-1:0]) state_d = ST_LINK;
      ST_LINK: state_d = (lvl_q == LVL_PD) ? ST_LEAF : ST_READ;
      ST_LEAF: state_d = ST_DONE;
      ST_DONE: if (rsp_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- datapath and memory control ----
  always_comb begin
    cnt_d       = cnt_q;
    nfree_d     = nfree_q;
    page_d      = page_q;
    alloc_d     = alloc_q;
    lvl_d       = lvl_q;
    req_d       = req_q;
    res_d       = res_q;
    nx_d        = nx_q;
    w_d         = w_q;
    u_d         = u_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    tbl_we      = 1'b0;
    tbl_wa      = {page_q, cur_idx};
    tbl_ra      = {page_q, cur_idx};
    tbl_wd      = '0;

    if (rsp_valid_q && rsp_o.ready) rsp_valid_d = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        tbl_we = 1'b1;
        tbl_wa = cnt_q;
        cnt_d  = cnt_q + AW'(1);
      end
      ST_IDLE: begin
        if (req_fire) begin
          req_d  = req_i.data;
          lvl_d  = LVL_ROOT;
          page_d = '0;
          res_d  = '0;
          if (noncanon && req_i.data.opcode != OP_UNMAP) res_d.status = STS_NONCANON;
        end
      end
      ST_EVAL: begin
        nx_d = nx_acc;
        w_d  = w_acc;
        u_d  = u_acc;
        unique case (act)
          ACT_FIN: begin
            res_d        = '0;
            res_d.status = fin_sts;
            if (fin_sts == STS_OK) begin
              res_d.out_phys      = res_phys;
              res_d.is_writable   = w_acc;
              res_d.is_executable = !(nxen_q && nx_acc);
              res_d.is_global     = mem_rd_q[8];
              res_d.is_user       = u_acc;
              res_d.was_accessed  = mem_rd_q[5];
              res_d.was_dirty     = mem_rd_q[6];
            end
          end
          ACT_ALLOC: begin
            alloc_d = nfree_q[PW-1:0];
            nfree_d = nfree_q + NW'(1);
            cnt_d   = '0;
          end
          ACT_LEAF: begin
            page_d = e_off[PW-1:0];
            lvl_d  = LVL_PT;
          end
          default: begin
            page_d = e_off[PW-1:0];
            lvl_d  = lvl_q + 2'd1;
          end
        endcase
      end
      ST_ZERO: begin
        tbl_we = 1'b1;
        tbl_wa = {alloc_q, cnt_q[IDX_W-1:0]};
        cnt_d  = cnt_q + AW'(1);
      end
      ST_LINK: begin
        tbl_we = 1'b1;
        tbl_wd = alloc_ent;
        page_d = alloc_q;
        lvl_d  = lvl_q + 2'd1;
      end
      ST_LEAF: begin
        tbl_we       = 1'b1;
        tbl_wd       = is_map ? leaf_ent : '0;
        res_d.status = is_map ? STS_OK : STS_UNMAPPED;
      end
      ST_DONE: begin
        if (rsp_free) begin
          rsp_valid_d = 1'b1;
          rsp_d       = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      nfree_q     <= NW'(1);
      page_q      <= '0;
      alloc_q     <= '0;
      lvl_q       <= LVL_ROOT;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      nfree_q     <= nfree_d;
      page_q      <= page_d;
      alloc_q     <= alloc_d;
      lvl_q       <= lvl_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    rsp_q <= rsp_d;
    nx_q  <= nx_d;
    w_q   <= w_d;
    u_q   <= u_d;
  end

  // ---- assertions ----
  `FPTE_ASSERT(a_nfree_bound, clk_i, rst_ni, nfree_q <= NW'(TABLE_PAGES))
  `FPTE_ASSERT(a_nfree_step, clk_i, rst_ni, nfree_q != $past(nfree_q) |-> nfree_q == $past(nfree_q) + NW'(1))
  `FPTE_ASSERT(a_rsp_from_done, clk_i, rst_ni, $rose(rsp_valid_q) |-> $past(state_q) == ST_DONE)
  `FPTE_ASSERT(a_no_write_idle, clk_i, rst_ni, tbl_we |-> state_q != ST_IDLE && state_q != ST_DONE)

endmodule

// ----- dv/four_level_page_table_engine_tb.sv -----
module four_level_page_table_engine_tb;
  import fpte_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAGES = 64;
  localparam logic [63:0] LOW_TOP  = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] HIGH_BOT = 64'hFFFF_8000_0000_0000;
  localparam logic [63:0] VA_MASK  = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] PHYS_MASK = 64'h000F_FFFF_FFFF_FFFF;

  class page_walk_scoreboard;
    logic [63:0] tbl [PAGES*512];
    int unsigned next_free;
    logic [39:0] base_frame;
    logic [63:0] kbound;
    logic        nx_on;
    fpte_rsp_t   pending_translations[$];
    int unsigned errors;
    int unsigned status_seen[8];

    function new();
      foreach (tbl[i]) tbl[i] = '0;
      next_free  = 1;
      base_frame = BASE_RST;
      kbound     = KBND_RST;
      nx_on      = 1'b1;
      errors     = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned slot(int unsigned page, logic [63:0] va, int shift);
      return page * 512 + int'((va >> shift) & 64'h1FF);
    endfunction

    function bit table_page(logic [63:0] e, output int unsigned page);
      logic [39:0] off;
      off = e[51:12] - base_frame;
      page = off[6:0];
      return off < PAGES;
    endfunction

    function bit non_canonical(logic [63:0] v);
      return v > LOW_TOP && v < HIGH_BOT;
    endfunction

    function fpte_rsp_t walk_resolve(logic [63:0] full);
      logic [63:0] va, e, offm, phys;
      logic nxb, wb, ub;
      int unsigned page;
      int shift;
      fpte_rsp_t r;
      r = '0;
      va = full & VA_MASK;
      offm = 64'hFFF;
      if (non_canonical(full)) begin
        r.status = STS_NONCANON;
        return r;
      end
      e = tbl[slot(0, va, 39)];
      if (!e[0]) begin
        r.status = STS_NOMAP;
        return r;
      end
      nxb = e[63]; wb = e[1]; ub = e[2];
      shift = 30;
      forever begin
        if (!table_page(e, page)) begin
          r.status = STS_NOMAP;
          return r;
        end
        e = tbl[slot(page, va, shift)];
        if (!e[0]) begin
          r.status = STS_NOMAP;
          return r;
        end
        nxb |= e[63]; wb &= e[1]; ub &= e[2];
        if (shift == 12) break;
        if (e[7]) begin
          offm = (shift == 30) ? 64'h3FFF_FFFF : 64'h1F_FFFF;
          break;
        end
        shift -= 9;
      end
      phys = (((e & ADDR_MASK) & ~offm) + (va & offm)) & PHYS_MASK;
      r.status        = STS_OK;
      r.out_phys      = phys[51:0];
      r.is_writable   = wb;
      r.is_executable = !(nx_on && nxb);
      r.is_global     = e[8];
      r.is_user       = ub;
      r.was_accessed  = e[5];
      r.was_dirty     = e[6];
      return r;
    endfunction

    function logic [2:0] walk_map(fpte_req_t q);
      logic [63:0] va, e, pte;
      int unsigned page, s, np;
      page = 0;
      va = q.virt_addr & VA_MASK;
      if (non_canonical(q.virt_addr)) return STS_NONCANON;
      for (int shift = 39; shift >= 21; shift -= 9) begin
        s = slot(page, va, shift);
        e = tbl[s];
        if (!e[0]) begin
          if (next_free >= PAGES) return STS_NOMEM;
          np = next_free++;
          for (int i = 0; i < 512; i++) tbl[np*512 + i] = '0;
          e = '0;
          e[51:12] = base_frame + np;
          e[1:0] = 2'b11;
          e[2] = q.virt_addr < kbound;
          tbl[s] = e;
        end else if (shift != 39 && e[7]) begin
          return STS_LARGE;
        end
        if (!table_page(e, page)) return STS_NOMEM;
      end
      pte = ({12'b0, q.phys_addr} & ADDR_MASK) | 64'h1;
      pte[1]  = q.want_write;
      pte[8]  = q.want_global;
      pte[2]  = q.want_user;
      pte[63] = !q.want_exec && nx_on;
      tbl[slot(page, va, 12)] = pte;
      return STS_OK;
    endfunction

    function logic [2:0] walk_unmap(logic [63:0] full);
      logic [63:0] va, e;
      int unsigned page;
      page = 0;
      va = full & VA_MASK;
      for (int shift = 39; shift >= 21; shift -= 9) begin
        e = tbl[slot(page, va, shift)];
        if (!e[0]) return STS_NOTHING;
        if (shift != 39 && e[7]) return STS_LARGE;
        if (!table_page(e, page)) return STS_NOTHING;
      end
      tbl[slot(page, va, 12)] = '0;
      return STS_UNMAPPED;
    endfunction

    function void note_request(fpte_req_t q);
      fpte_rsp_t r;
      r = '0;
      if (q.opcode == OP_MAP) r.status = walk_map(q);
      else if (q.opcode == OP_UNMAP) r.status = walk_unmap(q.virt_addr);
      else r = walk_resolve(q.virt_addr);
      pending_translations.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    task check_response(fpte_rsp_t got);
      fpte_rsp_t w;
      if (pending_translations.size() == 0) begin
        report("unexpected word", got.status, 0);
        return;
      end
      w = pending_translations.pop_front();
      status_seen[w.status]++;
      if (got.status !== w.status) report("status", got.status, w.status);
      if (got.out_phys !== w.out_phys) report("out_phys", got.out_phys, w.out_phys);
      if (got.is_writable !== w.is_writable)
        report("is_writable", got.is_writable, w.is_writable);
      if (got.is_executable !== w.is_executable)
        report("is_executable", got.is_executable, w.is_executable);
      if (got.is_global !== w.is_global) report("is_global", got.is_global, w.is_global);
      if (got.is_user !== w.is_user) report("is_user", got.is_user, w.is_user);
      if (got.was_accessed !== w.was_accessed)
        report("was_accessed", got.was_accessed, w.was_accessed);
      if (got.was_dirty !== w.was_dirty) report("was_dirty", got.was_dirty, w.was_dirty);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  fpte_chan_if #(.T(fpte_req_t)) req_if ();
  fpte_chan_if #(.T(fpte_rsp_t)) rsp_if ();

  four_level_page_table_engine #(.TABLE_PAGES(PAGES)) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  page_walk_scoreboard sb = new();
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_cycles = 0;
  logic [63:0] last_mapped = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      rsp_if.ready = 1'b0;
      hold_cycles--;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) sb.note_request(req_if.data);
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
  end

  task reg_write(logic [1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_BASE: sb.base_frame = val[39:0];
      REG_KBND: sb.kbound = val;
      default:  sb.nx_on = val[0];
    endcase
  endtask

  task push(fpte_req_t q);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.data  = q;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task push_op(logic [1:0] op, logic [63:0] va, logic [51:0] pa, logic [3:0] wants);
    fpte_req_t q;
    q.opcode = op;
    q.virt_addr = va;
    q.phys_addr = pa;
    {q.want_write, q.want_exec, q.want_global, q.want_user} = wants;
    push(q);
  endtask

  task drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (sb.pending_translations.size() != 0) @(posedge clk_i);
  endtask

  // Addresses drawn from a small set of upper-level table indexes so walks share tables
  // and the allocator runs dry part way through.
  function logic [63:0] pool_addr();
    logic [8:0] r, l3, l2, l1;
    logic [63:0] va;
    int unsigned k;
    k = $urandom_range(5);
    r = (k == 0) ? 9'd0 : (k == 1) ? 9'd1 : (k == 2) ? 9'd2 :
        (k == 3) ? 9'd255 : (k == 4) ? 9'd256 : 9'd511;
    k = $urandom_range(2);
    l3 = (k == 0) ? 9'd0 : (k == 1) ? 9'd1 : 9'd511;
    k = $urandom_range(3);
    l2 = (k == 3) ? 9'd511 : 9'(k);
    l1 = ($urandom_range(1) == 0) ? 9'($urandom_range(3)) : 9'($urandom);
    va = {{16{r[8]}}, r, l3, l2, l1, 12'($urandom)};
    return va;
  endfunction

  task random_items(int unsigned n, ref int unsigned sent);
    fpte_req_t q;
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      if (sent == 533) begin
        send_idle = 88; recv_idle = 32;
      end else if (sent == 1066) begin
        send_idle = 0; recv_idle = 0;
        hold_cycles = 400;
      end
      k = $urandom_range(99);
      q.opcode = (k < 40) ? OP_MAP : (k < 80) ? OP_RESOLVE : (k < 95) ? OP_UNMAP : 2'd3;
      k = $urandom_range(99);
      if (k < 30) q.virt_addr = last_mapped | 64'($urandom_range(4095));
      else if (k < 90) q.virt_addr = pool_addr();
      else if (k < 95) q.virt_addr = {$urandom, $urandom};
      else q.virt_addr = {16'($urandom), 48'(pool_addr())};
      if ($urandom_range(3) == 0) q.phys_addr = {20'($urandom), $urandom};
      else q.phys_addr = {sb.base_frame + 40'($urandom_range(70)), 12'($urandom)};
      {q.want_write, q.want_exec, q.want_global, q.want_user} = 4'($urandom);
      if (q.opcode == OP_MAP) last_mapped = q.virt_addr & ~64'hFFF;
      push(q);
      sent++;
    end
    drain();
  endtask

  initial begin
    int unsigned sent;
    sent = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    reg_write(REG_BASE, 64'd256);
    reg_write(REG_KBND, KBND_RST);
    reg_write(REG_NXEN, 64'd1);
    send_idle = 32; recv_idle = 88;

    // directed: empty tree, canonical edges, flag extremes, unmap paths
    push_op(OP_RESOLVE, 64'h0, 52'h0, 4'h0);
    push_op(OP_RESOLVE, 64'h0000_8000_0000_0000, 52'h0, 4'h0);
    push_op(OP_RESOLVE, 64'hFFFF_7FFF_FFFF_FFFF, 52'h0, 4'h0);
    push_op(OP_MAP, 64'h0000_8000_0000_0000, 52'h0, 4'hF);
    push_op(OP_UNMAP, 64'h0, 52'h0, 4'h0);
    push_op(OP_MAP, 64'h0, 52'hF_FFFF_FFFF_FFFF, 4'hF);
    push_op(OP_RESOLVE, 64'h0000_0000_0000_0FFF, 52'h0, 4'h0);
    push_op(OP_MAP, 64'h1000, 52'h1234_5000, 4'h0);
    push_op(2'd3, 64'h1ABC, 52'h0, 4'h0);
    push_op(OP_MAP, 64'h1000, 52'hA_BCDE_F012_3FFF, 4'hA);
    push_op(OP_RESOLVE, 64'h1FFF, 52'h0, 4'h0);
    push_op(OP_MAP, 64'hFFFF_FFFF_FFFF_F000, 52'h0, 4'h5);
    push_op(OP_RESOLVE, 64'hFFFF_FFFF_FFFF_FFFF, 52'h0, 4'h0);
    push_op(OP_RESOLVE, 64'h0000_7FFF_FFFF_FFFF, 52'h0, 4'h0);
    push_op(OP_UNMAP, 64'h2000, 52'h0, 4'h0);
    push_op(OP_UNMAP, 64'h1000, 52'h0, 4'h0);
    push_op(OP_RESOLVE, 64'h1000, 52'h0, 4'h0);
    push_op(OP_UNMAP, 64'h1234_FFFF_FFFF_F000, 52'h0, 4'h0);
    push_op(OP_RESOLVE, 64'hFFFF_FFFF_FFFF_F000, 52'h0, 4'h0);
    push_op(OP_UNMAP, 64'h0000_0040_0000_0000, 52'h0, 4'h0);
    drain();

    random_items(400, sent);
    reg_write(REG_KBND, 64'h0);
    reg_write(REG_NXEN, 64'h0);
    random_items(300, sent);
    reg_write(REG_KBND, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(REG_NXEN, 64'h1);
    random_items(300, sent);
    reg_write(REG_BASE, 64'h0);
    random_items(150, sent);
    reg_write(REG_BASE, 64'hFF_FFFF_FFFF);
    random_items(150, sent);
    reg_write(REG_BASE, 64'd256);
    reg_write(REG_KBND, 64'h0000_8000_0000_0000);
    random_items(300, sent);

    repeat (20) @(posedge clk_i);
    $display("covered %0d random words plus directed ones over six register settings",
             sent);
    $display("status counts ok %0d nomap %0d noncanon %0d nomem %0d unmapped %0d none %0d",
             sb.status_seen[STS_OK], sb.status_seen[STS_NOMAP],
             sb.status_seen[STS_NONCANON], sb.status_seen[STS_NOMEM],
             sb.status_seen[STS_UNMAPPED], sb.status_seen[STS_NOTHING]);
    if (sb.errors == 0 && sb.pending_translations.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/fpte_pkg.sv
sv/fpte_chan_if.sv
sv/four_level_page_table_engine.sv
dv/four_level_page_table_engine_tb.sv
